// ===== rtl/rcmu_pkg.sv =====
// Shared operation codes and fixed field widths for the route operator unit.
`timescale 1ns / 1ps

package rcmu_pkg;

    localparam int CMD_BITS       = 3;
    localparam int POS_BITS       = 3;
    localparam int SCR_ORDER_BITS = 8;
    localparam int SCR_IDX_BITS   = 2;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_CROSS    = 3'd0,
        CMD_INSERT   = 3'd1,
        CMD_SWAP     = 3'd2,
        CMD_INVERT   = 3'd3,
        CMD_SCRAMBLE = 3'd4
    } t_cmd;

endpackage

// ===== rtl/route_crossover_mutation_unit_core.sv =====
// Top level of the route operator unit: input register, operators, result register.
`timescale 1ns / 1ps

// Usage
// The request channel (i_in_valid / o_in_stall) carries one beat per
// operation: an opcode, two packed routes, two positions and a scramble order.
// The result channel (o_out_valid / i_out_stall) returns exactly one beat per
// request, in order: the child or mutated route and a bad-request flag.
// A beat moves at a rising edge where valid is high and stall is low.
// A request beat loads the input register; the result register loads from it
// when the pipeline advances, and o_out_valid is high while the result
// register holds the beat, which moves on when the receiver does not stall.
// Unstalled throughput is one beat per cycle; two registers form a two-entry
// pipeline that advances whenever the result register is empty or drained.
// When the receiver stalls, the result register holds its beat, the input
// register takes one more request if empty; only then is o_in_stall raised.
// o_in_stall follows i_out_stall in the same cycle when both registers hold.
// Synchronous active-low reset empties both registers; payload is not reset.
// The unit keeps no state between requests, so nothing else needs clearing.

module route_crossover_mutation_unit_core
    import rcmu_pkg::*;
#(
    parameter int GENES     = 7,
    parameter int CITY_BITS = 3,
    parameter int WINDOW    = 4,
    parameter int SEGMENT   = 3
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [CMD_BITS-1:0]        i_cmd,
    input  logic [GENES*CITY_BITS-1:0] i_route_a,
    input  logic [GENES*CITY_BITS-1:0] i_route_b,
    input  logic [POS_BITS-1:0]        i_pos_first,
    input  logic [POS_BITS-1:0]        i_pos_second,
    input  logic [SCR_ORDER_BITS-1:0]  i_scramble_order,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [GENES*CITY_BITS-1:0] o_route_out,
    output logic                       o_bad_request
);

    localparam int PW = $clog2(GENES);
    localparam int RB = GENES * CITY_BITS;

    // Request register.
    logic                      r_in_valid;
    logic [CMD_BITS-1:0]       r_in_cmd;
    logic [RB-1:0]             r_in_route_a;
    logic [RB-1:0]             r_in_route_b;
    logic [POS_BITS-1:0]       r_in_pos_first;
    logic [POS_BITS-1:0]       r_in_pos_second;
    logic [SCR_ORDER_BITS-1:0] r_in_scramble_order;

    // Result register.
    logic          r_out_valid;
    logic [RB-1:0] r_out_route;
    logic          r_out_bad;

    logic          advance;
    logic          in_load;
    logic [PW-1:0] p1;
    logic [PW-1:0] p2;
    logic [RB-1:0] cross_route;
    logic [RB-1:0] mut_route;
    logic          mut_bad;
    logic [RB-1:0] n_route;
    logic          n_bad;

    // The pipeline moves whenever the result register can give up its beat.
    assign advance    = !(r_out_valid && i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_load    = !o_in_stall;

    // Positions arrive below eight, so one conditional subtract folds them.
    always_comb begin
        p1 = PW'((int'(r_in_pos_first) >= GENES) ?
                 int'(r_in_pos_first) - GENES : int'(r_in_pos_first));
        p2 = PW'((int'(r_in_pos_second) >= GENES) ?
                 int'(r_in_pos_second) - GENES : int'(r_in_pos_second));
    end

    rcmu_cross #(
        .GENES     (GENES),
        .CITY_BITS (CITY_BITS),
        .SEGMENT   (SEGMENT),
        .PW        (PW)
    ) u_cross (
        .i_route_a (r_in_route_a),
        .i_route_b (r_in_route_b),
        .i_start   (p1),
        .o_child   (cross_route)
    );

    rcmu_mutate #(
        .GENES     (GENES),
        .CITY_BITS (CITY_BITS),
        .WINDOW    (WINDOW),
        .PW        (PW)
    ) u_mutate (
        .i_cmd            (r_in_cmd),
        .i_route_a        (r_in_route_a),
        .i_p1             (p1),
        .i_p2             (p2),
        .i_p2_raw         (r_in_pos_second),
        .i_scramble_order (r_in_scramble_order),
        .o_route          (mut_route),
        .o_bad            (mut_bad)
    );

    // Crossover never flags a request; every other code goes to the mutator.
    always_comb begin
        case (r_in_cmd)
            CMD_CROSS: begin
                n_route = cross_route;
                n_bad   = 1'b0;
            end
            default: begin
                n_route = mut_route;
                n_bad   = mut_bad;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_load) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_load && i_in_valid) begin
            r_in_cmd            <= i_cmd;
            r_in_route_a        <= i_route_a;
            r_in_route_b        <= i_route_b;
            r_in_pos_first      <= i_pos_first;
            r_in_pos_second     <= i_pos_second;
            r_in_scramble_order <= i_scramble_order;
        end
        if (advance && r_in_valid) begin
            r_out_route <= n_route;
            r_out_bad   <= n_bad;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_route_out   = r_out_route;
    assign o_bad_request = r_out_bad;

    // The request side only stalls when a request is already held.
    a_stall_needs_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid)
        else $error("request stall raised with an empty input register");

    // An accepted request beat always lands in the input register.
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> r_in_valid)
        else $error("accepted request was lost");

    // A crossover result is never flagged.
    a_cross_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && advance && r_in_cmd == CMD_CROSS) |=> (o_out_valid && !o_bad_request))
        else $error("crossover result flagged as bad");

    // Unknown operation codes are always flagged.
    a_unknown_bad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && advance && r_in_cmd > CMD_SCRAMBLE) |=> o_bad_request)
        else $error("unknown operation not flagged");

    // A flagged request returns route A unchanged.
    a_bad_passes_a: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && advance && n_bad) |=> (o_route_out == $past(r_in_route_a)))
        else $error("rejected request altered the route");

endmodule

// ===== rtl/rcmu_cross.sv =====
// Order crossover: segment copied from parent A, remaining slots filled from parent B.
`timescale 1ns / 1ps

module rcmu_cross
    import rcmu_pkg::*;
#(
    parameter int GENES     = 7,
    parameter int CITY_BITS = 3,
    parameter int SEGMENT   = 3,
    parameter int PW        = $clog2(GENES)
) (
    input  logic [GENES*CITY_BITS-1:0] i_route_a,
    input  logic [GENES*CITY_BITS-1:0] i_route_b,
    input  logic [PW-1:0]              i_start,
    output logic [GENES*CITY_BITS-1:0] o_child
);

    localparam int RW = $clog2(GENES + 1);

    // Folds a value below twice the route length back into a position.
    function automatic logic [PW-1:0] wrap(input int unsigned x);
        int unsigned y;
        y = (x >= GENES) ? x - GENES : x;
        return PW'(y);
    endfunction

    logic [CITY_BITS-1:0] ga [GENES];
    logic [CITY_BITS-1:0] gb [GENES];
    logic [PW-1:0]        last;
    logic [PW-1:0]        scan_idx [GENES];
    logic                 hit      [GENES];
    logic [RW-1:0]        rank     [GENES];
    logic [RW-1:0]        cnt;
    logic [PW-1:0]        off;
    logic [CITY_BITS-1:0] gene;

    always_comb begin
        for (int p = 0; p < GENES; p++) begin
            ga[p] = i_route_a[CITY_BITS*p +: CITY_BITS];
            gb[p] = i_route_b[CITY_BITS*p +: CITY_BITS];
        end
        last = wrap(int'(i_start) + SEGMENT - 1);

        // Scan parent B once, starting just after the segment, and rank the
        // genes that are not among the segment genes.
        cnt = '0;
        for (int s = 0; s < GENES; s++) begin
            scan_idx[s] = wrap(int'(last) + s + 1);
            hit[s] = 1'b0;
            for (int j = 0; j < SEGMENT; j++) begin
                if (gb[scan_idx[s]] == ga[wrap(int'(i_start) + j)]) begin
                    hit[s] = 1'b1;
                end
            end
            rank[s] = cnt;
            if (!hit[s]) begin
                cnt = cnt + RW'(1);
            end
        end

        // Each position is either in the segment or is fill slot off-SEGMENT.
        o_child = '0;
        for (int p = 0; p < GENES; p++) begin
            off  = wrap(p + GENES - int'(i_start));
            gene = gb[p];
            if (int'(off) < SEGMENT) begin
                gene = ga[p];
            end else begin
                for (int s = 0; s < GENES; s++) begin
                    if (!hit[s] && int'(rank[s]) == int'(off) - SEGMENT) begin
                        gene = gb[scan_idx[s]];
                    end
                end
            end
            o_child[CITY_BITS*p +: CITY_BITS] = gene;
        end
    end

endmodule

// ===== rtl/rcmu_mutate.sv =====
// Insert, swap, invert and scramble mutations on one route, with request checks.
`timescale 1ns / 1ps

module rcmu_mutate
    import rcmu_pkg::*;
#(
    parameter int GENES     = 7,
    parameter int CITY_BITS = 3,
    parameter int WINDOW    = 4,
    parameter int PW        = $clog2(GENES)
) (
    input  logic [CMD_BITS-1:0]        i_cmd,
    input  logic [GENES*CITY_BITS-1:0] i_route_a,
    input  logic [PW-1:0]              i_p1,
    input  logic [PW-1:0]              i_p2,
    input  logic [POS_BITS-1:0]        i_p2_raw,
    input  logic [SCR_ORDER_BITS-1:0]  i_scramble_order,
    output logic [GENES*CITY_BITS-1:0] o_route,
    output logic                       o_bad
);

    function automatic logic [PW-1:0] wrap(input int unsigned x);
        int unsigned y;
        y = (x >= GENES) ? x - GENES : x;
        return PW'(y);
    endfunction

    logic [CITY_BITS-1:0]    ga  [GENES];
    logic [CITY_BITS-1:0]    res [GENES];
    logic [SCR_IDX_BITS-1:0] idx [WINDOW];
    logic                    order_bad;
    int                      k;

    always_comb begin
        for (int p = 0; p < GENES; p++) begin
            ga[p]  = i_route_a[CITY_BITS*p +: CITY_BITS];
            res[p] = ga[p];
        end

        // Scramble order check: every index inside the window, no repeats.
        order_bad = 1'b0;
        for (int i = 0; i < WINDOW; i++) begin
            if (2 * i < SCR_ORDER_BITS) begin
                idx[i] = i_scramble_order[SCR_IDX_BITS*i +: SCR_IDX_BITS];
            end else begin
                idx[i] = '0;
            end
            if (int'(idx[i]) >= WINDOW) begin
                order_bad = 1'b1;
            end
            for (int j = 0; j < i; j++) begin
                if (idx[j] == idx[i]) begin
                    order_bad = 1'b1;
                end
            end
        end

        o_bad = 1'b0;
        k     = 0;
        case (i_cmd)
            CMD_INSERT: begin
                if (int'(i_p2_raw) > GENES - 2) begin
                    o_bad = 1'b1;
                end else begin
                    for (int i = 0; i < GENES; i++) begin
                        k = (i < int'(i_p2_raw)) ? i : i - 1;
                        k = (k < int'(i_p1)) ? k : k + 1;
                        if (i == int'(i_p2_raw)) begin
                            res[i] = ga[i_p1];
                        end else begin
                            res[i] = ga[PW'(k)];
                        end
                    end
                end
            end
            CMD_SWAP: begin
                res[i_p1] = ga[i_p2];
                res[i_p2] = ga[i_p1];
            end
            CMD_INVERT: begin
                for (int i = 0; i < WINDOW; i++) begin
                    res[wrap(int'(i_p1) + i)] = ga[wrap(int'(i_p1) + WINDOW - 1 - i)];
                end
            end
            CMD_SCRAMBLE: begin
                if (order_bad) begin
                    o_bad = 1'b1;
                end else begin
                    for (int i = 0; i < WINDOW; i++) begin
                        res[wrap(int'(i_p1) + i)] = ga[wrap(int'(i_p1) + int'(idx[i]))];
                    end
                end
            end
            default: begin
                o_bad = 1'b1;
            end
        endcase

        o_route = '0;
        for (int p = 0; p < GENES; p++) begin
            o_route[CITY_BITS*p +: CITY_BITS] = o_bad ? ga[p] : res[p];
        end
    end

endmodule

// ===== tb/route_result_checker.sv =====
// Result checker for the route operator unit: predicts each request and compares results.
`timescale 1ns / 1ps

module route_result_checker
    import rcmu_pkg::*;
#(
    parameter int GENES     = 7,
    parameter int CITY_BITS = 3,
    parameter int WINDOW    = 4,
    parameter int SEGMENT   = 3
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic                       i_in_stall,
    input  logic [CMD_BITS-1:0]        i_cmd,
    input  logic [GENES*CITY_BITS-1:0] i_route_a,
    input  logic [GENES*CITY_BITS-1:0] i_route_b,
    input  logic [POS_BITS-1:0]        i_pos_first,
    input  logic [POS_BITS-1:0]        i_pos_second,
    input  logic [SCR_ORDER_BITS-1:0]  i_scramble_order,
    input  logic                       i_out_valid,
    input  logic                       i_out_stall,
    input  logic [GENES*CITY_BITS-1:0] i_route_out,
    input  logic                       i_bad_request,
    output int                         o_mismatches,
    output int                         o_outstanding
);

    typedef logic [CITY_BITS-1:0] t_gene;
    typedef logic [GENES-1:0][CITY_BITS-1:0] t_genes;

    typedef struct packed {
        t_genes route;
        logic   bad;
    } t_route_result;

    t_route_result expected_routes[$];
    int            mismatch_count = 0;

    // Computes the route and the reject flag that one request must produce.
    function automatic t_route_result predict_route(
        logic [CMD_BITS-1:0]       cmd,
        t_genes                    ga,
        t_genes                    gb,
        logic [POS_BITS-1:0]       pos_first,
        logic [POS_BITS-1:0]       pos_second,
        logic [SCR_ORDER_BITS-1:0] order
    );
        t_route_result     r;
        t_genes            res;
        t_gene             seg [SEGMENT];
        t_gene             win [WINDOW];
        t_gene             rest [GENES];
        int                p1, p2, last, placed, k, idx, i, j, s;
        logic              hit, bad;
        logic [WINDOW-1:0] seen;
        int                sel [WINDOW];

        res = ga;
        bad = 1'b0;
        p1  = int'(pos_first) % GENES;
        case (cmd)
            CMD_CROSS: begin
                res    = gb;
                last   = (p1 + SEGMENT - 1) % GENES;
                placed = 0;
                for (j = 0; j < SEGMENT; j++) seg[j] = ga[(p1 + j) % GENES];
                // Scan parent B once, starting after the segment, and fill the
                // free positions in order with genes not already in the segment.
                for (s = 1; s <= GENES; s++) begin
                    idx = (last + s) % GENES;
                    hit = 1'b0;
                    for (j = 0; j < SEGMENT; j++) if (gb[idx] == seg[j]) hit = 1'b1;
                    if (!hit && placed < GENES - SEGMENT) begin
                        res[(last + 1 + placed) % GENES] = gb[idx];
                        placed++;
                    end
                end
                for (j = 0; j < SEGMENT; j++) res[(p1 + j) % GENES] = seg[j];
            end
            CMD_INSERT: begin
                if (int'(pos_second) > GENES - 2) begin
                    bad = 1'b1;
                end else begin
                    k = 0;
                    for (i = 0; i < GENES; i++) begin
                        if (i != p1) begin
                            rest[k] = ga[i];
                            k++;
                        end
                    end
                    k = 0;
                    for (i = 0; i < GENES; i++) begin
                        if (i == int'(pos_second)) begin
                            res[i] = ga[p1];
                        end else begin
                            res[i] = rest[k];
                            k++;
                        end
                    end
                end
            end
            CMD_SWAP: begin
                p2      = int'(pos_second) % GENES;
                res[p1] = ga[p2];
                res[p2] = ga[p1];
            end
            CMD_INVERT: begin
                for (i = 0; i < WINDOW; i++) win[i] = ga[(p1 + i) % GENES];
                for (i = 0; i < WINDOW; i++) res[(p1 + WINDOW - 1 - i) % GENES] = win[i];
            end
            CMD_SCRAMBLE: begin
                seen = '0;
                for (i = 0; i < WINDOW; i++) begin
                    sel[i] = int'(order[SCR_IDX_BITS*i +: SCR_IDX_BITS]);
                    if (sel[i] >= WINDOW || seen[sel[i]]) bad = 1'b1;
                    else seen[sel[i]] = 1'b1;
                end
                if (!bad) begin
                    for (i = 0; i < WINDOW; i++) win[i] = ga[(p1 + i) % GENES];
                    for (i = 0; i < WINDOW; i++) res[(p1 + i) % GENES] = win[sel[i]];
                end
            end
            default: begin
                bad = 1'b1;
            end
        endcase
        r.route = res;
        r.bad   = bad;
        return r;
    endfunction

    task automatic note_mismatch(string what, t_route_result want, t_route_result got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("%0t: %s: expected route %h bad %b, got route %h bad %b",
                     $realtime, what, want.route, want.bad, got.route, got.bad);
        end
    endtask

    always @(posedge i_clk) begin
        t_route_result got;
        t_route_result want;
        if (i_rst_n) begin
            if (i_in_valid && !i_in_stall) begin
                expected_routes = {expected_routes, predict_route(i_cmd, i_route_a,
                    i_route_b, i_pos_first, i_pos_second, i_scramble_order)};
            end
            if (i_out_valid && !i_out_stall) begin
                got.route = i_route_out;
                got.bad   = i_bad_request;
                if (expected_routes.size() == 0) begin
                    want = '0;
                    note_mismatch("result beat with no request waiting", want, got);
                end else begin
                    want = expected_routes.pop_front();
                    if (got.route !== want.route || got.bad !== want.bad) begin
                        note_mismatch("result mismatch", want, got);
                    end
                end
            end
        end
        o_mismatches  <= mismatch_count;
        o_outstanding <= expected_routes.size();
    end

endmodule

// ===== tb/route_crossover_mutation_unit_core_test.sv =====
// Top of the route operator unit test: clock, reset, request stimulus and verdict.
`timescale 1ns / 1ps

module route_crossover_mutation_unit_core_test;
    import rcmu_pkg::*;

    localparam int GENES        = 7;
    localparam int CITY_BITS    = 3;
    localparam int ROUTE_W      = GENES * CITY_BITS;
    localparam int RANDOM_ITEMS = 630;
    // Cycles with no beat on either channel before the run is declared hung.
    // The longest legitimate quiet stretch is a sender gap during a stall burst.
    localparam int IDLE_LIMIT   = 1000;
    // Margin waited out at the end, after the last result has been checked.
    localparam int DRAIN_CYCLES = 4;

    localparam logic [ROUTE_W-1:0] ROUTE_ASCENDING =
        {3'd6, 3'd5, 3'd4, 3'd3, 3'd2, 3'd1, 3'd0};
    localparam logic [ROUTE_W-1:0] ROUTE_DESCENDING =
        {3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6};
    localparam logic [ROUTE_W-1:0] ROUTE_MIXED =
        {3'd2, 3'd5, 3'd0, 3'd6, 3'd3, 3'd1, 3'd4};
    localparam logic [SCR_ORDER_BITS-1:0] ORDER_KEEP    = 8'b11_10_01_00;
    localparam logic [SCR_ORDER_BITS-1:0] ORDER_REVERSE = 8'b00_01_10_11;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } t_stall_mode;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_in_valid;
    logic                      o_in_stall;
    logic [CMD_BITS-1:0]       i_cmd;
    logic [ROUTE_W-1:0]        i_route_a;
    logic [ROUTE_W-1:0]        i_route_b;
    logic [POS_BITS-1:0]       i_pos_first;
    logic [POS_BITS-1:0]       i_pos_second;
    logic [SCR_ORDER_BITS-1:0] i_scramble_order;
    logic                      o_out_valid;
    logic                      i_out_stall;
    logic [ROUTE_W-1:0]        o_route_out;
    logic                      o_bad_request;

    int          mismatches;
    int          outstanding;
    int          burst_left  = 0;
    int          quiet_count = 0;
    int          stall_left  = 0;
    int          stall_tick  = 0;
    t_stall_mode stall_mode  = STALL_NONE;

    route_crossover_mutation_unit_core i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_cmd            (i_cmd),
        .i_route_a        (i_route_a),
        .i_route_b        (i_route_b),
        .i_pos_first      (i_pos_first),
        .i_pos_second     (i_pos_second),
        .i_scramble_order (i_scramble_order),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_route_out      (o_route_out),
        .o_bad_request    (o_bad_request)
    );

    // The checker watches both channels on its own, predicts every accepted
    // request and compares it with the result beats as they leave the block.
    route_result_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_in_stall       (o_in_stall),
        .i_cmd            (i_cmd),
        .i_route_a        (i_route_a),
        .i_route_b        (i_route_b),
        .i_pos_first      (i_pos_first),
        .i_pos_second     (i_pos_second),
        .i_scramble_order (i_scramble_order),
        .i_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .i_route_out      (o_route_out),
        .i_bad_request    (o_bad_request),
        .o_mismatches     (mismatches),
        .o_outstanding    (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // The receiver switches between stall styles at random so that result beats
    // meet free flow, light and heavy back-pressure, and a regular on/off rhythm.
    always @(posedge i_clk) begin
        stall_tick <= stall_tick + 1;
        if (stall_left == 0) begin
            stall_mode <= t_stall_mode'($urandom_range(0, 3));
            stall_left <= $urandom_range(20, 150);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            STALL_NONE:     i_out_stall <= 1'b0;
            STALL_LIGHT:    i_out_stall <= ($urandom_range(0, 99) < 30);
            STALL_HEAVY:    i_out_stall <= ($urandom_range(0, 99) < 75);
            default:        i_out_stall <= ((stall_tick % 5) < 2);
        endcase
    end

    // Watchdog: any beat on either channel restarts the count, so only a real
    // hang ends the run here.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_count <= 0;
        end else if (quiet_count >= IDLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_count <= quiet_count + 1;
        end
    end

    // A random route: half the time a proper tour of cities 0..6, some tours that
    // use city 7 so the top bit of each gene toggles, and some raw noise with
    // repeated genes that exercises the crossover's duplicate handling.
    function automatic logic [ROUTE_W-1:0] random_route();
        logic [CITY_BITS-1:0] cities [8];
        logic [CITY_BITS-1:0] t;
        logic [ROUTE_W-1:0]   r;
        int                   kind, n, j, pick;
        kind = $urandom_range(0, 9);
        if (kind < 2) begin
            r = ROUTE_W'($urandom());
            return r;
        end
        for (j = 0; j < 8; j++) cities[j] = CITY_BITS'(j);
        n = (kind < 7) ? GENES : 8;
        for (j = n - 1; j > 0; j--) begin
            pick         = $urandom_range(0, j);
            t            = cities[j];
            cities[j]    = cities[pick];
            cities[pick] = t;
        end
        for (j = 0; j < GENES; j++) r[CITY_BITS*j +: CITY_BITS] = cities[j];
        return r;
    endfunction

    // Most scramble orders are true permutations of the window; the rest are
    // random bytes, which are usually rejected.
    function automatic logic [SCR_ORDER_BITS-1:0] random_order();
        logic [SCR_IDX_BITS-1:0]   idx [4];
        logic [SCR_IDX_BITS-1:0]   t;
        logic [SCR_ORDER_BITS-1:0] o;
        int                        j, pick;
        if ($urandom_range(0, 3) == 0) begin
            o = SCR_ORDER_BITS'($urandom());
            return o;
        end
        for (j = 0; j < 4; j++) idx[j] = SCR_IDX_BITS'(j);
        for (j = 3; j > 0; j--) begin
            pick      = $urandom_range(0, j);
            t         = idx[j];
            idx[j]    = idx[pick];
            idx[pick] = t;
        end
        for (j = 0; j < 4; j++) o[SCR_IDX_BITS*j +: SCR_IDX_BITS] = idx[j];
        return o;
    endfunction

    // Bursts of random length separated by random gaps. A gap of zero lets
    // two bursts run together, so long back-to-back stretches also occur.
    task automatic pace_sender();
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
    endtask

    // Presents one request beat and holds it steady until the block takes it.
    // Valid stays high into the next beat unless the pacing opens a gap.
    task automatic send_request(
        logic [CMD_BITS-1:0]       cmd,
        logic [ROUTE_W-1:0]        route_a,
        logic [ROUTE_W-1:0]        route_b,
        logic [POS_BITS-1:0]       pos_first,
        logic [POS_BITS-1:0]       pos_second,
        logic [SCR_ORDER_BITS-1:0] order
    );
        pace_sender();
        i_in_valid       <= 1'b1;
        i_cmd            <= cmd;
        i_route_a        <= route_a;
        i_route_b        <= route_b;
        i_pos_first      <= pos_first;
        i_pos_second     <= pos_second;
        i_scramble_order <= order;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Holds off the sender until every request has produced its result. The
    // first wait lets the checker count the beat accepted at this very edge.
    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        burst_left  = 0;
        do @(posedge i_clk); while (outstanding != 0);
    endtask

    initial begin
        int                  n, c;
        logic [CMD_BITS-1:0] cmd;

        i_rst_n          <= 1'b0;
        i_in_valid       <= 1'b0;
        i_cmd            <= CMD_CROSS;
        i_route_a        <= '0;
        i_route_b        <= '0;
        i_pos_first      <= '0;
        i_pos_second     <= '0;
        i_scramble_order <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Crossover: plain segment, a segment that wraps past the last gene,
        // a start position past the end, and a parent B full of one gene so
        // that nothing gets placed and the fill keeps parent B's genes.
        send_request(CMD_CROSS, ROUTE_ASCENDING, ROUTE_DESCENDING, 3'd0, 3'd0, 8'h00);
        send_request(CMD_CROSS, ROUTE_MIXED, ROUTE_ASCENDING, 3'd6, 3'd0, 8'h00);
        send_request(CMD_CROSS, ROUTE_DESCENDING, ROUTE_MIXED, 3'd7, 3'd7, 8'hFF);
        send_request(CMD_CROSS, '0, '1, 3'd2, 3'd0, 8'h00);
        send_request(CMD_CROSS, '1, '1, 3'd4, 3'd0, 8'h00);

        // Insert: to the highest accepted target, to the front, both rejected
        // targets, and a source position past the end, which folds to gene 0.
        send_request(CMD_INSERT, ROUTE_ASCENDING, '0, 3'd0, 3'd5, 8'h00);
        send_request(CMD_INSERT, ROUTE_MIXED, '0, 3'd6, 3'd0, 8'h00);
        send_request(CMD_INSERT, ROUTE_ASCENDING, '0, 3'd2, 3'd6, 8'h00);
        send_request(CMD_INSERT, ROUTE_MIXED, '1, 3'd3, 3'd7, 8'hFF);
        send_request(CMD_INSERT, ROUTE_DESCENDING, '0, 3'd7, 3'd3, 8'h00);

        // Swap: a gene with itself, the two ends, and a second position past
        // the end.
        send_request(CMD_SWAP, ROUTE_MIXED, '0, 3'd4, 3'd4, 8'h00);
        send_request(CMD_SWAP, ROUTE_ASCENDING, '0, 3'd0, 3'd6, 8'h00);
        send_request(CMD_SWAP, ROUTE_DESCENDING, '0, 3'd5, 3'd7, 8'h00);

        // Invert: window at the start, a window that wraps, start past the end.
        send_request(CMD_INVERT, ROUTE_ASCENDING, '0, 3'd0, 3'd0, 8'h00);
        send_request(CMD_INVERT, ROUTE_MIXED, '0, 3'd5, 3'd0, 8'h00);
        send_request(CMD_INVERT, ROUTE_DESCENDING, '0, 3'd7, 3'd0, 8'h00);

        // Scramble: order that keeps the window, a reversing order on a
        // wrapping window, and two orders that repeat an index.
        send_request(CMD_SCRAMBLE, ROUTE_MIXED, '0, 3'd1, 3'd0, ORDER_KEEP);
        send_request(CMD_SCRAMBLE, ROUTE_ASCENDING, '0, 3'd4, 3'd0, ORDER_REVERSE);
        send_request(CMD_SCRAMBLE, ROUTE_ASCENDING, '0, 3'd0, 3'd0, 8'h00);
        send_request(CMD_SCRAMBLE, ROUTE_DESCENDING, '1, 3'd7, 3'd7, 8'hFF);

        // Every opcode above the defined set must be rejected.
        for (c = CMD_SCRAMBLE + 1; c < 2**CMD_BITS; c++) begin
            send_request(c[CMD_BITS-1:0], ROUTE_MIXED, ROUTE_ASCENDING, 3'd3, 3'd2,
                         ORDER_KEEP);
        end

        wait_for_results();

        // Random requests. Unknown opcodes are kept rare so that most beats
        // exercise real operators; every so often the sender waits until the
        // pipeline is fully empty.
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 150 == 149) wait_for_results();
            if ($urandom_range(0, 99) < 6) begin
                cmd = CMD_BITS'($urandom_range(CMD_SCRAMBLE + 1, 2**CMD_BITS - 1));
            end else begin
                cmd = CMD_BITS'($urandom_range(CMD_CROSS, CMD_SCRAMBLE));
            end
            send_request(cmd, random_route(), random_route(),
                         POS_BITS'($urandom_range(0, 7)),
                         POS_BITS'($urandom_range(0, 7)), random_order());
        end

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/rcmu_pkg.sv
rtl/rcmu_cross.sv
rtl/rcmu_mutate.sv
rtl/route_crossover_mutation_unit_core.sv
tb/route_result_checker.sv
tb/route_crossover_mutation_unit_core_test.sv
